FILE: rtl/assert_macros.svh
// assertion helpers shared by fct_queue and fct_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define FCT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// implication checked in the same cycle outside reset
`define FCT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

FILE: rtl/fct_pkg.sv
`timescale 1ns / 1ps
package fct_pkg;

  localparam int CNT_W   = 64;
  localparam int ID_W    = 8;
  localparam int LEN_W   = 16;
  localparam int LIVE_W  = 7;
  localparam int Q_DEPTH = 2;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_QUERY  = 3'd3;
  localparam logic [2:0] CMD_INCR   = 3'd4;
  localparam logic [2:0] CMD_DUMP   = 3'd5;
  localparam logic [2:0] CMD_DELALL = 3'd6;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef enum logic [3:0] {
    OP_PASS,
    OP_BAD,
    OP_CREATE,
    OP_DELETE,
    OP_CLEAR,
    OP_QUERY,
    OP_INCR,
    OP_DUMP,
    OP_DELALL
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_NOEXIST = 2'd2,
    ST_EMPTY   = 2'd3
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INCR,
    S_QUERY,
    S_DUMP,
    S_DUMP_OUT
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } q_item_t;

endpackage

FILE: rtl/flow_counter_table_core.sv
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    command, flow_id, byte_length
// out      output     out_valid / out_stall  status, reported_id, packet/byte count,
//                                            live_counters, last
// cfg      input      cfg_wr_en              cfg_wr_data (id_limit)
//
// create, delete, clear, delete all, bad ids and unused codes finish in S_IDLE of the back end;
// query and increment of a live counter also pass through S_QUERY or S_INCR (registered read of the counter ram)
// dump leaves S_IDLE, then scans slots up to the last live counter, reading and emitting each live one
// a 2-item queue sits between classifier and executor; results wait in the out register
// reset clears valid bits and live count and sets id_limit to 64 at once; no clearing pass
// out_stall holds the result register and backs up the queue, then in_stall
module flow_counter_table_core
  import fct_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [ID_W-1:0]    in_flow_id,
  input  logic [LEN_W-1:0]   in_byte_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [ID_W-1:0]    out_reported_id,
  output logic [CNT_W-1:0]   out_packet_count,
  output logic [CNT_W-1:0]   out_byte_count,
  output logic [LIVE_W-1:0]  out_live_counters,
  output logic               out_last
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic                 q_full, q_push, q_pop, q_valid;
  q_item_t              q_in, q_head;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [2*CNT_W-1:0]   ram_wdata, ram_rdata;

  fct_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_flow_id     (in_flow_id),
    .in_byte_length (in_byte_length),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  fct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  fct_ram #(.WIDTH(2 * CNT_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  fct_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .ram_we            (ram_we),
    .ram_re            (ram_re),
    .ram_addr          (ram_addr),
    .ram_wdata         (ram_wdata),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_reported_id   (out_reported_id),
    .out_packet_count  (out_packet_count),
    .out_byte_count    (out_byte_count),
    .out_live_counters (out_live_counters),
    .out_last          (out_last)
  );

endmodule

FILE: rtl/fct_ram.sv
`timescale 1ns / 1ps
module fct_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/fct_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fct_queue
  import fct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output q_item_t head_item
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  q_item_t         mem_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign full       = (count_r == CW'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  `FCT_ASSERT_IMPL(a_no_overflow, clk, rst_n, count_r == CW'(Q_DEPTH), !push)
  `FCT_ASSERT_IMPL(a_no_underflow, clk, rst_n, count_r == '0, !pop)

endmodule

FILE: rtl/fct_front.sv
`timescale 1ns / 1ps
module fct_front
  import fct_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic [ID_W-1:0]   in_flow_id,
  input  logic [LEN_W-1:0]  in_byte_length,
  input  logic              q_full,
  output logic              q_push,
  output q_item_t           q_item
);

  logic [6:0] id_limit_r;
  logic       bad;
  op_t        op;
  logic [ID_W-1:0] rep_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r <= 7'd64;
    end else if (cfg_wr_en) begin
      id_limit_r <= cfg_wr_data;
    end
  end

  assign bad = ({1'b0, in_flow_id} >= {2'b00, id_limit_r}) ||
               ({1'b0, in_flow_id} >= 9'(TABLE_DEPTH));

  // classify the item so the back end only sees what it has to do
  always_comb begin
    op     = OP_PASS;
    rep_id = in_flow_id;
    priority if (in_command == CMD_DUMP) begin
      op = OP_DUMP;
    end else if (in_command == CMD_DELALL) begin
      op     = OP_DELALL;
      rep_id = '0;
    end else if (in_command == CMD_UNUSED) begin
      op = OP_PASS;
    end else if (in_flow_id == '0) begin
      op = (in_command == CMD_QUERY) ? OP_BAD : OP_PASS;
    end else if (bad) begin
      op = OP_BAD;
    end else begin
      unique case (in_command)
        CMD_CREATE: op = OP_CREATE;
        CMD_DELETE: op = OP_DELETE;
        CMD_CLEAR:  op = OP_CLEAR;
        CMD_QUERY:  op = OP_QUERY;
        CMD_INCR:   op = OP_INCR;
        default:    op = OP_PASS;
      endcase
    end
  end

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign q_item.op  = op;
  assign q_item.id  = rep_id;
  assign q_item.len = in_byte_length;

endmodule

FILE: rtl/fct_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fct_back
  import fct_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  q_item_t                       q_head,
  output logic                          q_pop,
  output logic                          ram_we,
  output logic                          ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_addr,
  output logic [2*CNT_W-1:0]            ram_wdata,
  input  logic [2*CNT_W-1:0]            ram_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [ID_W-1:0]               out_reported_id,
  output logic [CNT_W-1:0]              out_packet_count,
  output logic [CNT_W-1:0]              out_byte_count,
  output logic [LIVE_W-1:0]             out_live_counters,
  output logic                          out_last
);

  localparam int AW = $clog2(TABLE_DEPTH);

  back_state_t            state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [LIVE_W-1:0]      total_r, total_nxt;
  logic [LIVE_W-1:0]      emitted_r, emitted_nxt;
  logic [AW-1:0]          scan_r, scan_nxt;
  q_item_t                cur_r, cur_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r;
  logic [ID_W-1:0]        out_id_r;
  logic [CNT_W-1:0]       out_pk_r, out_by_r;
  logic [LIVE_W-1:0]      out_live_r;
  logic                   out_last_r;

  logic                   out_free, out_load;
  st_t                    res_status;
  logic [ID_W-1:0]        res_id;
  logic [CNT_W-1:0]       res_pk, res_by;
  logic                   res_last;
  logic [AW-1:0]          head_idx, cur_idx;
  logic                   hit, dump_last;
  logic [CNT_W-1:0]       rd_pk, rd_by;

  assign out_free  = !out_valid_r || !out_stall;
  assign head_idx  = q_head.id[AW-1:0];
  assign cur_idx   = cur_r.id[AW-1:0];
  assign hit       = valid_r[head_idx];
  assign rd_pk     = ram_rdata[2*CNT_W-1:CNT_W];
  assign rd_by     = ram_rdata[CNT_W-1:0];
  assign dump_last = ((emitted_r + LIVE_W'(1)) == total_r);

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    total_nxt   = total_r;
    emitted_nxt = emitted_r;
    scan_nxt    = scan_r;
    cur_nxt     = cur_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = head_idx;
    ram_wdata   = '0;
    out_load    = 1'b0;
    res_status  = ST_OK;
    res_id      = q_head.id;
    res_pk      = '0;
    res_by      = '0;
    res_last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          unique case (q_head.op)
            OP_PASS: begin
              out_load = 1'b1;
            end
            OP_BAD: begin
              out_load   = 1'b1;
              res_status = ST_BAD;
            end
            OP_CREATE: begin
              out_load = 1'b1;
              if (!hit) begin
                ram_we              = 1'b1;
                valid_nxt[head_idx] = 1'b1;
                total_nxt           = total_r + LIVE_W'(1);
              end
            end
            OP_DELETE: begin
              out_load = 1'b1;
              if (hit) begin
                valid_nxt[head_idx] = 1'b0;
                total_nxt           = total_r - LIVE_W'(1);
              end else begin
                res_status = ST_NOEXIST;
              end
            end
            OP_CLEAR: begin
              out_load = 1'b1;
              if (hit) begin
                ram_we = 1'b1;
              end else begin
                res_status = ST_NOEXIST;
              end
            end
            OP_QUERY: begin
              if (hit) begin
                ram_re    = 1'b1;
                state_nxt = S_QUERY;
              end else begin
                out_load   = 1'b1;
                res_status = ST_NOEXIST;
              end
            end
            OP_INCR: begin
              out_load = 1'b1;
              if (hit) begin
                ram_re    = 1'b1;
                state_nxt = S_INCR;
              end else begin
                // missing counter starts at one packet and this length
                ram_we              = 1'b1;
                ram_wdata           = {CNT_W'(1), CNT_W'(q_head.len)};
                valid_nxt[head_idx] = 1'b1;
                total_nxt           = total_r + LIVE_W'(1);
              end
            end
            OP_DUMP: begin
              if (total_r == '0) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
                res_id     = '0;
              end else begin
                scan_nxt    = '0;
                emitted_nxt = '0;
                state_nxt   = S_DUMP;
              end
            end
            OP_DELALL: begin
              out_load  = 1'b1;
              res_id    = '0;
              valid_nxt = '0;
              total_nxt = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_INCR: begin
        ram_we    = 1'b1;
        ram_addr  = cur_idx;
        ram_wdata = {rd_pk + CNT_W'(1), rd_by + CNT_W'(cur_r.len)};
        state_nxt = S_IDLE;
      end
      S_QUERY: begin
        res_id = cur_r.id;
        if (out_free) begin
          out_load  = 1'b1;
          res_pk    = rd_pk;
          res_by    = rd_by;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        ram_addr = scan_r;
        if (valid_r[scan_r]) begin
          ram_re    = 1'b1;
          state_nxt = S_DUMP_OUT;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      S_DUMP_OUT: begin
        ram_addr = scan_r;
        res_id   = ID_W'(scan_r);
        if (out_free) begin
          out_load = 1'b1;
          res_pk   = rd_pk;
          res_by   = rd_by;
          res_last = dump_last;
          // the live count tells when the last entry has gone out
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            emitted_nxt = emitted_r + LIVE_W'(1);
            scan_nxt    = scan_r + AW'(1);
            state_nxt   = S_DUMP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emitted_r <= emitted_nxt;
    scan_r    <= scan_nxt;
    cur_r     <= cur_nxt;
    if (out_load) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_pk_r     <= res_pk;
      out_by_r     <= res_by;
      out_live_r   <= total_nxt;
      out_last_r   <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_reported_id   = out_id_r;
  assign out_packet_count  = out_pk_r;
  assign out_byte_count    = out_by_r;
  assign out_live_counters = out_live_r;
  assign out_last          = out_last_r;

  `FCT_ASSERT(a_total_range, clk, rst_n, total_r <= LIVE_W'(TABLE_DEPTH))
  `FCT_ASSERT_IMPL(a_dump_hit, clk, rst_n, state_r == S_DUMP_OUT, valid_r[scan_r])
  `FCT_ASSERT_IMPL(a_dump_count, clk, rst_n,
    state_r == S_DUMP || state_r == S_DUMP_OUT, emitted_r < total_r)
  `FCT_ASSERT_IMPL(a_load_free, clk, rst_n, out_load, out_free)

endmodule
